@@ design/two_level_lru_cache_tag_model_macros.svh @@
// ----------------------------------------------------------------------------
// Two-level cache tag model: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_LRU_CACHE_TAG_MODEL_MACROS_SVH
`define TWO_LEVEL_LRU_CACHE_TAG_MODEL_MACROS_SVH

// same-cycle implication
`define TLC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tlc_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-level cache tag model package
// Register indexes, access kinds and result codes.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_SIZE_LOG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS_LOG    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_SIZE_LOG    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS_LOG    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 3'd5;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [1:0] SERVED_L1  = 2'd0;
    localparam logic [1:0] SERVED_L2  = 2'd1;
    localparam logic [1:0] SERVED_MEM = 2'd2;

endpackage

@@ design/tlc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ design/two_level_lru_cache_tag_model.sv @@
// ----------------------------------------------------------------------------
// Two-level cache tag model
// Input channel: i_in_valid / o_in_stall carry a read or write byte address.
// Output channel: o_out_valid / i_out_stall carry where the access was served
// and whether a dirty L1 victim was written back into L2.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_wdata; write
// only while no access is in flight.
// One access at a time. A single compare/age unit walks the ways of a set,
// each way taking a RAM read state and then an evaluate and write-back state.
// The input is ready for a new transfer in the cycle after the result is loaded.
// After reset a clearing pass over max(L1 depth, L2 depth) addresses (2048 by
// default) zeroes both tag RAMs; o_in_stall is high during it.
// A finished result sits in an output register; if the receiver stalls, the
// next result waits in the sequencer until the register is taken, and the
// input stays stalled meanwhile.
// ----------------------------------------------------------------------------
`include "two_level_lru_cache_tag_model_macros.svh"

module two_level_lru_cache_tag_model #(
    parameter int L1_WAYS_MAX = 4,
    parameter int L1_SETS_MAX = 64,
    parameter int L2_WAYS_MAX = 8,
    parameter int L2_SETS_MAX = 256,
    parameter int ADDR_BITS   = 32,
    parameter int AGE_BITS    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tlc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic [31:0]                    i_address,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_served_from,
    output logic                           o_victim_written_back
);

    localparam int L1_DEPTH  = L1_WAYS_MAX * L1_SETS_MAX;
    localparam int L2_DEPTH  = L2_WAYS_MAX * L2_SETS_MAX;
    localparam int L1_IW     = (L1_DEPTH > 1) ? $clog2(L1_DEPTH) : 1;
    localparam int L2_IW     = (L2_DEPTH > 1) ? $clog2(L2_DEPTH) : 1;
    localparam int MAX_DEPTH = (L1_DEPTH > L2_DEPTH) ? L1_DEPTH : L2_DEPTH;
    localparam int CLR_W     = $clog2(MAX_DEPTH + 1);
    localparam int SW1       = (L1_SETS_MAX > 1) ? $clog2(L1_SETS_MAX) : 1;
    localparam int SW2       = (L2_SETS_MAX > 1) ? $clog2(L2_SETS_MAX) : 1;
    localparam int SLOG1_MAX = $clog2(L1_SETS_MAX + 1) - 1;
    localparam int SLOG2_MAX = $clog2(L2_SETS_MAX + 1) - 1;
    localparam int WAYS_MX   = (L1_WAYS_MAX > L2_WAYS_MAX) ? L1_WAYS_MAX : L2_WAYS_MAX;
    localparam int WW        = (WAYS_MX > 1) ? $clog2(WAYS_MX) : 1;
    localparam int ENT_W     = ADDR_BITS + 2 + AGE_BITS;
    localparam int DTY_B     = AGE_BITS;
    localparam int VAL_B     = AGE_BITS + 1;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_EV, S_FW, S_DONE} t_state;
    typedef enum logic [2:0] {
        ST_P1, ST_MARK1, ST_P2, ST_MARK2, ST_FILL1, ST_WB2, ST_FILL2, ST_REPL1
    } t_step;

    t_state r_state;
    t_step  r_step;

    logic [3:0]           r_block_bits;
    logic [4:0]           r_l1_size_log;
    logic [1:0]           r_l1_ways_log;
    logic [4:0]           r_l2_size_log;
    logic [1:0]           r_l2_ways_log;
    logic                 r_write_allocate;

    logic [CLR_W-1:0]     r_clr;
    logic                 r_mode;
    logic [ADDR_BITS-1:0] r_blk;
    logic [WW-1:0]        r_way;
    logic                 r_found;
    logic [WW-1:0]        r_hit;
    logic [WW-1:0]        r_best;
    logic [AGE_BITS-1:0]  r_oldest;
    logic [ADDR_BITS-1:0] r_vblk;
    logic                 r_vval;
    logic                 r_vdty;
    logic [1:0]           r_served;
    logic                 r_wb;
    logic                 r_out_valid;
    logic [1:0]           r_out_served;
    logic                 r_out_wb;

    logic [63:0]          w_addr64;
    logic [ADDR_BITS-1:0] w_blk_in;
    logic [4:0]           w_slog1;
    logic [4:0]           w_slog2;
    logic [WW:0]          w_nways1;
    logic [WW:0]          w_nways2;
    logic                 w_lvl2;
    logic [ADDR_BITS-1:0] w_key;
    logic [ADDR_BITS-1:0] w_msk1;
    logic [ADDR_BITS-1:0] w_msk2;
    logic [ADDR_BITS-1:0] w_msk;
    logic [SW1-1:0]       w_set1;
    logic [SW2-1:0]       w_set2;
    logic [L1_IW-1:0]     w_idx1;
    logic [L2_IW-1:0]     w_idx2;
    logic [ENT_W-1:0]     w_rd1;
    logic [ENT_W-1:0]     w_rd2;
    logic [ENT_W-1:0]     w_rd;
    logic [ADDR_BITS-1:0] w_eblk;
    logic                 w_eval;
    logic                 w_edty;
    logic [AGE_BITS-1:0]  w_eage;
    logic [AGE_BITS-1:0]  w_age_inc;
    logic                 w_match;
    logic                 w_last;
    logic                 w_hit_any;
    logic [WW-1:0]        w_hit_way;
    logic                 w_cap;
    logic [WW-1:0]        w_best;
    logic                 w_fdirty;
    logic                 w_alloc;
    logic                 w_we;
    logic [ENT_W-1:0]     w_wd;
    logic                 w_we1;
    logic                 w_we2;
    logic [L1_IW-1:0]     w_waddr1;
    logic [L2_IW-1:0]     w_waddr2;
    logic                 w_in_acc;

    assign w_addr64 = {32'b0, i_address};
    assign w_blk_in = w_addr64[ADDR_BITS-1:0] >> r_block_bits;
    assign w_fdirty = (r_mode == tlc_pkg::MODE_WRITE);
    assign w_alloc  = (r_mode == tlc_pkg::MODE_READ) || r_write_allocate;
    assign w_in_acc = i_in_valid && !o_in_stall;

    always_comb begin
        int s1;
        int s2;
        int n1;
        int n2;
        s1 = int'(r_l1_size_log) - int'(r_block_bits) - int'(r_l1_ways_log);
        s2 = int'(r_l2_size_log) - int'(r_block_bits) - int'(r_l2_ways_log);
        if (s1 < 0) s1 = 0;
        if (s2 < 0) s2 = 0;
        if (s1 > SLOG1_MAX) s1 = SLOG1_MAX;
        if (s2 > SLOG2_MAX) s2 = SLOG2_MAX;
        n1 = 1 << r_l1_ways_log;
        n2 = 1 << r_l2_ways_log;
        if (n1 > L1_WAYS_MAX) n1 = L1_WAYS_MAX;
        if (n2 > L2_WAYS_MAX) n2 = L2_WAYS_MAX;
        w_slog1  = 5'(s1);
        w_slog2  = 5'(s2);
        w_nways1 = (WW + 1)'(n1);
        w_nways2 = (WW + 1)'(n2);
    end

    assign w_lvl2 = (r_step == ST_P2) || (r_step == ST_MARK2) ||
                    (r_step == ST_WB2) || (r_step == ST_FILL2);
    assign w_key  = ((r_step == ST_WB2) || (r_step == ST_REPL1)) ? r_vblk : r_blk;
    assign w_msk1 = ~({ADDR_BITS{1'b1}} << w_slog1);
    assign w_msk2 = ~({ADDR_BITS{1'b1}} << w_slog2);
    assign w_msk  = w_lvl2 ? w_msk2 : w_msk1;
    assign w_set1 = SW1'(w_key & w_msk1);
    assign w_set2 = SW2'(w_key & w_msk2);
    assign w_idx1 = L1_IW'(int'(r_way) * L1_SETS_MAX + int'(w_set1));
    assign w_idx2 = L2_IW'(int'(r_way) * L2_SETS_MAX + int'(w_set2));

    assign w_rd      = w_lvl2 ? w_rd2 : w_rd1;
    assign w_eblk    = w_rd[ENT_W-1 -: ADDR_BITS];
    assign w_eval    = w_rd[VAL_B];
    assign w_edty    = w_rd[DTY_B];
    assign w_eage    = w_rd[AGE_BITS-1:0];
    assign w_age_inc = (w_eage == {AGE_BITS{1'b1}}) ? w_eage : w_eage + 1'b1;
    assign w_match   = w_eval && (((w_eblk ^ w_key) & ~w_msk) == '0);
    assign w_last    = (r_step == ST_MARK1) || (r_step == ST_MARK2) ||
                       (int'(r_way) == int'(w_lvl2 ? w_nways2 : w_nways1) - 1);
    assign w_hit_any = r_found || w_match;
    assign w_hit_way = w_match ? r_way : r_hit;
    assign w_cap     = (r_way == '0) || (w_eage > r_oldest);
    assign w_best    = w_cap ? r_way : r_best;

    always_comb begin
        w_we = 1'b0;
        w_wd = w_rd;
        case (r_state)
            S_EV: begin
                case (r_step)
                    ST_P1, ST_P2: begin
                        w_we = 1'b1;
                        w_wd = {w_eblk, w_eval, w_edty,
                                w_match ? {AGE_BITS{1'b0}} : w_age_inc};
                    end
                    ST_MARK1: begin
                        w_we = 1'b1;
                        w_wd = {w_eblk, w_eval, 1'b1, w_eage};
                    end
                    ST_MARK2: begin
                        w_we = 1'b1;
                        w_wd = {w_eblk, w_eval, 1'b1, {AGE_BITS{1'b0}}};
                    end
                    ST_WB2: begin
                        w_we = 1'b1;
                        w_wd = w_match ? {w_eblk, w_eval, 1'b1, {AGE_BITS{1'b0}}}
                                       : {w_eblk, w_eval, w_edty, w_age_inc};
                    end
                    ST_REPL1: begin
                        w_we = w_match;
                        w_wd = {r_blk, 1'b1, w_fdirty, {AGE_BITS{1'b0}}};
                    end
                    default: begin
                        w_we = 1'b0;
                    end
                endcase
            end
            S_FW: begin
                w_we = 1'b1;
                w_wd = {r_blk, 1'b1, (r_step == ST_FILL1) && w_fdirty, {AGE_BITS{1'b0}}};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign w_we1    = (r_state == S_CLEAR) ? (int'(r_clr) < L1_DEPTH) : (w_we && !w_lvl2);
    assign w_we2    = (r_state == S_CLEAR) ? (int'(r_clr) < L2_DEPTH) : (w_we && w_lvl2);
    assign w_waddr1 = (r_state == S_CLEAR) ? r_clr[L1_IW-1:0] : w_idx1;
    assign w_waddr2 = (r_state == S_CLEAR) ? r_clr[L2_IW-1:0] : w_idx2;

    tlc_ram #(.WIDTH(ENT_W), .DEPTH(L1_DEPTH)) u_l1_ram (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_waddr1),
        .i_wdata ((r_state == S_CLEAR) ? {ENT_W{1'b0}} : w_wd),
        .i_raddr (w_idx1),
        .o_rdata (w_rd1)
    );

    tlc_ram #(.WIDTH(ENT_W), .DEPTH(L2_DEPTH)) u_l2_ram (
        .i_clk   (i_clk),
        .i_we    (w_we2),
        .i_waddr (w_waddr2),
        .i_wdata ((r_state == S_CLEAR) ? {ENT_W{1'b0}} : w_wd),
        .i_raddr (w_idx2),
        .o_rdata (w_rd2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLEAR;
            r_step           <= ST_P1;
            r_clr            <= '0;
            r_block_bits     <= 4'd4;
            r_l1_size_log    <= 5'd12;
            r_l1_ways_log    <= 2'd2;
            r_l2_size_log    <= 5'd15;
            r_l2_ways_log    <= 2'd3;
            r_write_allocate <= 1'b1;
            r_out_valid      <= 1'b0;
            r_found          <= 1'b0;
            r_wb             <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tlc_pkg::CFG_BLOCK_BITS:     r_block_bits     <= i_cfg_wdata[3:0];
                    tlc_pkg::CFG_L1_SIZE_LOG:    r_l1_size_log    <= i_cfg_wdata;
                    tlc_pkg::CFG_L1_WAYS_LOG:    r_l1_ways_log    <= i_cfg_wdata[1:0];
                    tlc_pkg::CFG_L2_SIZE_LOG:    r_l2_size_log    <= i_cfg_wdata;
                    tlc_pkg::CFG_L2_WAYS_LOG:    r_l2_ways_log    <= i_cfg_wdata[1:0];
                    tlc_pkg::CFG_WRITE_ALLOCATE: r_write_allocate <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (int'(r_clr) == MAX_DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_mode  <= i_mode;
                        r_blk   <= w_blk_in;
                        r_step  <= ST_P1;
                        r_way   <= '0;
                        r_found <= 1'b0;
                        r_wb    <= 1'b0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    if ((r_step == ST_FILL1) || (r_step == ST_FILL2)) begin
                        if (w_cap) begin
                            r_best   <= r_way;
                            r_oldest <= w_eage;
                            r_vblk   <= w_eblk;
                            r_vval   <= w_eval;
                            r_vdty   <= w_edty;
                        end
                    end
                    if (!w_last) begin
                        r_way   <= r_way + 1'b1;
                        r_found <= w_hit_any;
                        r_hit   <= w_hit_way;
                        r_state <= S_RD;
                    end else begin
                        r_found <= 1'b0;
                        r_way   <= '0;
                        r_state <= S_RD;
                        case (r_step)
                            ST_P1: begin
                                if (w_hit_any) begin
                                    r_served <= tlc_pkg::SERVED_L1;
                                    if (w_fdirty) begin
                                        r_step <= ST_MARK1;
                                        r_way  <= w_hit_way;
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end else begin
                                    r_step <= ST_P2;
                                end
                            end
                            ST_P2: begin
                                if (w_hit_any) begin
                                    r_served <= tlc_pkg::SERVED_L2;
                                    if (w_alloc) begin
                                        r_step <= ST_FILL1;
                                    end else begin
                                        r_step <= ST_MARK2;
                                        r_way  <= w_hit_way;
                                    end
                                end else begin
                                    r_served <= tlc_pkg::SERVED_MEM;
                                    if (w_alloc) begin
                                        r_step <= ST_FILL2;
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end
                            end
                            ST_FILL1, ST_FILL2: begin
                                r_way   <= w_best;
                                r_state <= S_FW;
                            end
                            ST_REPL1: begin
                                if (!w_hit_any) begin
                                    r_step <= ST_FILL1;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FW: begin
                    r_way   <= '0;
                    r_found <= 1'b0;
                    r_state <= S_RD;
                    if (r_step == ST_FILL2) begin
                        r_step <= r_vval ? ST_REPL1 : ST_FILL1;
                    end else if (r_vval && r_vdty) begin
                        r_wb   <= 1'b1;
                        r_step <= ST_WB2;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_served <= r_served;
                        r_out_wb     <= r_wb;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall            = (r_state != S_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_served_from         = r_out_served;
    assign o_victim_written_back = r_out_wb;

    `TLC_ASSERT_NEXT(a_accept_starts_l1, i_clk, i_rst_n, w_in_acc, (r_state == S_RD) && (r_step == ST_P1), "accepted access did not start the L1 lookup")
    `TLC_ASSERT_NOW(a_mark1_writes, i_clk, i_rst_n, (r_state == S_EV) && (r_step == ST_MARK1), w_we1 && !w_we2, "L1 dirty mark did not write L1")
    `TLC_ASSERT_NOW(a_fill_writes, i_clk, i_rst_n, r_state == S_FW, w_we1 != w_we2, "fill did not write exactly one level")

endmodule

@@ test/tb_two_level_lru_cache_tag_model.sv @@
// ----------------------------------------------------------------------------
// Two-level cache tag model testbench
// Streams read/write accesses through the block under several geometries and
// idle/stall mixes, predicts each result with a behavioral tag model of both
// levels, and compares every transfer on the output channel in order.
// ----------------------------------------------------------------------------
module tb_two_level_lru_cache_tag_model;

    localparam int W1 = 4, S1 = 64, W2 = 8, S2 = 256;
    localparam logic [15:0] AGE_TOP = 16'hFFFF;

    typedef struct packed {
        logic       mode;
        logic [31:0] address;
    } t_access;

    typedef struct packed {
        logic [1:0] served;
        logic       wb;
    } t_outcome;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [tlc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [tlc_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic i_in_valid, o_in_stall, i_mode;
    logic [31:0] i_address;
    logic o_out_valid, i_out_stall;
    logic [1:0] o_served_from;
    logic o_victim_written_back;

    two_level_lru_cache_tag_model dut (.*);

    // predictor state
    logic [31:0] c1_blk [W1*S1];
    logic        c1_val [W1*S1];
    logic        c1_dty [W1*S1];
    logic [15:0] c1_age [W1*S1];
    logic [31:0] c2_blk [W2*S2];
    logic        c2_val [W2*S2];
    logic        c2_dty [W2*S2];
    logic [15:0] c2_age [W2*S2];
    int r_bb, r_l1s, r_l1w, r_l2s, r_l2w, r_wa;
    int g_slog [2];
    int g_ways [2];

    t_access  access_q [$];
    t_outcome outcome_q [$];
    int errors;
    int send_idle, recv_idle;
    int sent, got;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("tb_two_level_lru_cache_tag_model: FAIL");
        $finish;
    end

    function automatic void set_geometry();
        int s, lv;
        for (lv = 0; lv < 2; lv++) begin
            s = (lv ? r_l2s : r_l1s) - r_bb - (lv ? r_l2w : r_l1w);
            if (s < 0) s = 0;
            while (s > 0 && (1 << s) > (lv ? S2 : S1)) s--;
            g_slog[lv] = s;
            g_ways[lv] = 1 << (lv ? r_l2w : r_l1w);
            if (g_ways[lv] > (lv ? W2 : W1)) g_ways[lv] = lv ? W2 : W1;
        end
    endfunction

    function automatic logic tag_hit(int lv, int e, logic [31:0] blk);
        if (lv == 0) return c1_val[e] && ((c1_blk[e] >> g_slog[0]) == (blk >> g_slog[0]));
        return c2_val[e] && ((c2_blk[e] >> g_slog[1]) == (blk >> g_slog[1]));
    endfunction

    function automatic int set_idx(int lv, logic [31:0] blk);
        return int'(blk & ((32'd1 << g_slog[lv]) - 1));
    endfunction

    function automatic logic [15:0] older(logic [15:0] a);
        return (a < AGE_TOP) ? a + 16'd1 : a;
    endfunction

    // lookup with aging; also used for write-back with mark_dirty
    function automatic int lookup(int lv, logic [31:0] blk, logic mark_dirty);
        int w, e, hit, st;
        hit = -1;
        st = lv ? S2 : S1;
        for (w = 0; w < g_ways[lv]; w++) begin
            e = w * st + set_idx(lv, blk);
            if (tag_hit(lv, e, blk)) begin
                if (lv == 0) c1_age[e] = 0; else c2_age[e] = 0;
                if (mark_dirty) c2_dty[e] = 1;
                hit = w;
            end else if (lv == 0) c1_age[e] = older(c1_age[e]);
            else c2_age[e] = older(c2_age[e]);
        end
        return hit;
    endfunction

    function automatic void place(int lv, logic [31:0] blk, logic d,
                                  output logic [31:0] vb, output logic vv,
                                  output logic vd);
        int w, e, best, st;
        logic [15:0] top, a;
        best = 0; top = 0;
        st = lv ? S2 : S1;
        for (w = 0; w < g_ways[lv]; w++) begin
            e = w * st + set_idx(lv, blk);
            a = lv ? c2_age[e] : c1_age[e];
            if (a > top) begin
                top = a;
                best = w;
            end
        end
        e = best * st + set_idx(lv, blk);
        if (lv == 0) begin
            vb = c1_blk[e]; vv = c1_val[e]; vd = c1_dty[e];
            c1_age[e] = 0; c1_blk[e] = blk; c1_val[e] = 1; c1_dty[e] = d;
        end else begin
            vb = c2_blk[e]; vv = c2_val[e]; vd = c2_dty[e];
            c2_age[e] = 0; c2_blk[e] = blk; c2_val[e] = 1; c2_dty[e] = d;
        end
    endfunction

    function automatic t_outcome serve_access(t_access a);
        t_outcome r;
        logic [31:0] blk, vb;
        logic vv, vd, wr, alloc, moved;
        int h, e, w, dummy;
        wr = (a.mode == tlc_pkg::MODE_WRITE);
        blk = a.address >> r_bb;
        alloc = !wr || r_wa != 0;
        r.wb = 0;
        h = lookup(0, blk, 0);
        if (h >= 0) begin
            r.served = tlc_pkg::SERVED_L1;
            if (wr) c1_dty[h * S1 + set_idx(0, blk)] = 1;
        end else begin
            h = lookup(1, blk, 0);
            if (h >= 0) begin
                r.served = tlc_pkg::SERVED_L2;
                if (alloc) begin
                    place(0, blk, wr, vb, vv, vd);
                    if (vv && vd) begin
                        dummy = lookup(1, vb, 1);
                        r.wb = 1;
                    end
                end else begin
                    e = h * S2 + set_idx(1, blk);
                    c2_dty[e] = 1;
                    c2_age[e] = 0;
                end
            end else begin
                r.served = tlc_pkg::SERVED_MEM;
                if (alloc) begin
                    moved = 0;
                    place(1, blk, 0, vb, vv, vd);
                    if (vv) begin
                        for (w = 0; w < g_ways[0]; w++) begin
                            e = w * S1 + set_idx(0, vb);
                            if (tag_hit(0, e, vb)) begin
                                c1_age[e] = 0; c1_blk[e] = blk;
                                c1_val[e] = 1; c1_dty[e] = wr;
                                moved = 1;
                            end
                        end
                    end
                    if (!moved) begin
                        place(0, blk, wr, vb, vv, vd);
                        if (vv && vd) begin
                            dummy = lookup(1, vb, 1);
                            r.wb = 1;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                outcome_q.push_back(serve_access('{i_mode, i_address}));
                sent++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (access_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    i_in_valid <= 1;
                    {i_mode, i_address} <= access_q.pop_front();
                end else begin
                    i_in_valid <= 0;
                    i_mode <= 1'($urandom);
                    i_address <= $urandom;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got++;
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected transfer served=%0d wb=%0d", $time,
                             o_served_from, o_victim_written_back);
                    errors++;
                end else begin
                    exp_r = outcome_q.pop_front();
                    if (exp_r.served !== o_served_from) begin
                        $display("%0t: served_from expected %0d actual %0d", $time,
                                 exp_r.served, o_served_from);
                        errors++;
                    end
                    if (exp_r.wb !== o_victim_written_back) begin
                        $display("%0t: victim_written_back expected %0d actual %0d",
                                 $time, exp_r.wb, o_victim_written_back);
                        errors++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic write_reg(logic [tlc_pkg::CFG_IDX_W-1:0] idx, int v);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v[tlc_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            tlc_pkg::CFG_BLOCK_BITS:     r_bb = v & 15;
            tlc_pkg::CFG_L1_SIZE_LOG:    r_l1s = v & 31;
            tlc_pkg::CFG_L1_WAYS_LOG:    r_l1w = v & 3;
            tlc_pkg::CFG_L2_SIZE_LOG:    r_l2s = v & 31;
            tlc_pkg::CFG_L2_WAYS_LOG:    r_l2w = v & 3;
            tlc_pkg::CFG_WRITE_ALLOCATE: r_wa = v & 1;
            default: ;
        endcase
        set_geometry();
    endtask

    task automatic set_all(int bb, int s1, int w1, int s2, int w2, int wa);
        write_reg(tlc_pkg::CFG_BLOCK_BITS, bb);
        write_reg(tlc_pkg::CFG_L1_SIZE_LOG, s1);
        write_reg(tlc_pkg::CFG_L1_WAYS_LOG, w1);
        write_reg(tlc_pkg::CFG_L2_SIZE_LOG, s2);
        write_reg(tlc_pkg::CFG_L2_WAYS_LOG, w2);
        write_reg(tlc_pkg::CFG_WRITE_ALLOCATE, wa);
    endtask

    task automatic drain();
        while (access_q.size() > 0 || i_in_valid || outcome_q.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // random accesses mostly inside a small working set to hit and evict
    task automatic add_random(int n);
        logic [31:0] base, a;
        int k;
        base = $urandom;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1: a = $urandom;
                default: a = base ^ ($urandom & 32'h0000_3FFF) ^
                             ({2'($urandom_range(3)), 30'd0});
            endcase
            access_q.push_back('{logic'($urandom_range(1)), a});
        end
    endtask

    initial begin
        int ph, k;
        errors = 0; sent = 0; got = 0;
        send_idle = 0; recv_idle = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = 0; i_cfg_wdata = 0;
        i_in_valid = 0; i_mode = 0; i_address = 0; i_out_stall = 0;
        r_bb = 4; r_l1s = 12; r_l1w = 2; r_l2s = 15; r_l2w = 3; r_wa = 1;
        set_geometry();
        for (k = 0; k < W1*S1; k++) begin
            c1_blk[k] = 0; c1_val[k] = 0; c1_dty[k] = 0; c1_age[k] = 0;
        end
        for (k = 0; k < W2*S2; k++) begin
            c2_blk[k] = 0; c2_val[k] = 0; c2_dty[k] = 0; c2_age[k] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, reuse, write hits, eviction chains
        access_q.push_back('{tlc_pkg::MODE_READ, 32'h0});
        access_q.push_back('{tlc_pkg::MODE_READ, 32'h0});
        access_q.push_back('{tlc_pkg::MODE_WRITE, 32'h0});
        access_q.push_back('{tlc_pkg::MODE_WRITE, 32'hFFFF_FFFF});
        access_q.push_back('{tlc_pkg::MODE_READ, 32'hFFFF_FFFF});
        for (k = 0; k < 12; k++)
            access_q.push_back('{logic'(k[0]), 32'h0000_0000 + (k << 10)});
        access_q.push_back('{tlc_pkg::MODE_READ, 32'h0});
        access_q.push_back('{tlc_pkg::MODE_WRITE, 32'h0000_0400});
        access_q.push_back('{tlc_pkg::MODE_READ, 32'hAAAA_AAAA});
        access_q.push_back('{tlc_pkg::MODE_WRITE, 32'h5555_5555});
        drain();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_all(4, 12, 2, 15, 3, 0);
                1: set_all(0, 0, 0, 0, 0, 1);
                2: set_all(8, 16, 2, 20, 3, 1);
                3: set_all(15, 31, 3, 31, 3, 0);
                4: set_all(2, 6, 1, 9, 2, 1);
                5: set_all(0, 8, 2, 10, 3, 0);
                6: set_all(3, 7, 0, 8, 1, 1);
                default: set_all(1, 5, 2, 6, 3, 1);
            endcase
            case (ph % 4)
                0: begin send_idle = 0; recv_idle = 0; end
                1: begin send_idle = 45; recv_idle = 0; end
                2: begin send_idle = 0; recv_idle = 45; end
                default: begin send_idle = 34; recv_idle = 34; end
            endcase
            add_random(175);
            drain();
        end

        if (errors == 0) begin
            $display("tb_two_level_lru_cache_tag_model: PASS");
        end else begin
            $display("tb_two_level_lru_cache_tag_model: FAIL");
        end
        $finish;
    end
endmodule
